@@ hdl/chr_pkg.sv @@
package chr_pkg;

  // Phase fraction and multiplier digit count
  localparam int FRAC_BITS = 16;
  // Phase increment (Q8.16) and phase position widths
  localparam int INC_W = 24;
  localparam int POS_W = INC_W + 1;
  // Frame port and configuration port widths
  localparam int DATA_W = 64;
  localparam int CC_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = INC_W;
  // Results per input word, and the counter that tracks them
  localparam int OUT_CAP = 64;
  localparam int CNT_W = 7;
  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 2'd1;

endpackage

@@ hdl/chr_mul.sv @@
// Bit-serial signed-by-unsigned multiplier, multiplier MSB first.
module chr_mul import chr_pkg::*; #(
  parameter int Width = 56
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [Width-1:0] a_i,
  input  logic [FRAC_BITS-1:0]    b_i,
  output logic                    done_o,
  output logic signed [Width-1:0] p_o
);

  localparam int CntW = $clog2(FRAC_BITS + 1);

  logic signed [Width-1:0] a_q, acc_q;
  logic [FRAC_BITS-1:0]    b_q;
  logic [CntW-1:0]         cnt_q;
  logic                    done_q;

  // Control: digit counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CntW'(1));
      if (start_i) begin
        cnt_q <= CntW'(FRAC_BITS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Datapath: shift-and-add, one multiplier bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= (acc_q <<< 1) + (b_q[FRAC_BITS-1] ? a_q : '0);
      b_q   <= b_q << 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

@@ hdl/chr_hermite.sv @@
// One lane of Catmull-Rom interpolation: three serial multiplies by f.
module chr_hermite import chr_pkg::*; #(
  parameter int SampleBits = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [FRAC_BITS-1:0]         f_i,
  input  logic signed [SampleBits-1:0] xm1_i,
  input  logic signed [SampleBits-1:0] x0_i,
  input  logic signed [SampleBits-1:0] x1_i,
  input  logic signed [SampleBits-1:0] x2_i,
  output logic                         done_o,
  output logic [SampleBits-1:0]        y_o
);

  localparam int AccW = SampleBits + 40;
  localparam logic [1:0] PhC3 = 2'd0;
  localparam logic [1:0] PhC2 = 2'd1;
  localparam logic [1:0] PhC1 = 2'd2;
  localparam logic signed [AccW-1:0] YMax = AccW'((64'sd1 <<< (SampleBits - 1)) - 64'sd1);
  localparam logic signed [AccW-1:0] YMin = -YMax - AccW'(1);
  localparam logic signed [AccW-1:0] Half16 = AccW'(64'sd1 <<< 15);
  localparam logic signed [AccW-1:0] Half17 = AccW'(64'sd1 <<< 16);

  logic signed [AccW-1:0] xm1_e, x0_e, x1_e, x2_e, d_w;
  logic signed [AccW-1:0] c1_w, c2_w, c3_w;
  logic signed [AccW-1:0] c1_q, c2_q, x0_q;
  logic [FRAC_BITS-1:0]   f_q;
  logic [1:0]             ph_q;
  logic                   busy_q, done_q;
  logic [SampleBits-1:0]  y_q;

  logic                   mul_start, mul_done;
  logic signed [AccW-1:0] mul_a, prod, prod_r, t_w, y_w, y_sat;
  logic [FRAC_BITS-1:0]   mul_b;

  // Twice the Hermite coefficients
  assign xm1_e = AccW'(xm1_i);
  assign x0_e  = AccW'(x0_i);
  assign x1_e  = AccW'(x1_i);
  assign x2_e  = AccW'(x2_i);
  assign d_w   = x0_e - x1_e;
  assign c1_w  = x1_e - xm1_e;
  assign c2_w  = (xm1_e <<< 1) - ((x0_e <<< 2) + x0_e) + (x1_e <<< 2) - x2_e;
  assign c3_w  = (x2_e - xm1_e) + ((d_w <<< 1) + d_w);

  // Rounded product and final sample
  assign prod_r = (prod + Half16) >>> 16;
  assign t_w    = prod_r + (x0_q <<< 17);
  assign y_w    = (t_w + Half17) >>> 17;
  always_comb begin
    y_sat = y_w;
    if (y_w > YMax) y_sat = YMax;
    if (y_w < YMin) y_sat = YMin;
  end

  // Next multiply operand
  assign mul_start = start_i | (mul_done & busy_q & (ph_q != PhC1));
  assign mul_b     = start_i ? f_i : f_q;
  always_comb begin
    if (start_i) begin
      mul_a = c3_w;
    end else if (ph_q == PhC3) begin
      mul_a = prod + (c2_q <<< 16);
    end else begin
      mul_a = prod_r + (c1_q <<< 16);
    end
  end

  chr_mul #(.Width(AccW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (prod)
  );

  // Pass sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= PhC3;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && busy_q && mul_done && (ph_q == PhC1);
      if (start_i) begin
        busy_q <= 1'b1;
        ph_q   <= PhC3;
      end else if (busy_q && mul_done) begin
        unique case (ph_q)
          PhC3: ph_q <= PhC2;
          PhC2: ph_q <= PhC1;
          default: begin
            busy_q <= 1'b0;
          end
        endcase
      end
    end
  end

  // Operand and result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      c1_q <= c1_w;
      c2_q <= c2_w;
      x0_q <= x0_e;
      f_q  <= f_i;
    end
    if (busy_q && mul_done && ph_q == PhC1) begin
      y_q <= y_sat[SampleBits-1:0];
    end
  end

  assign done_o = done_q;
  assign y_o    = y_q;

endmodule

@@ hdl/cubic_hermite_resampler_unit.sv @@
// Four-point cubic Hermite resampler for packed multichannel frames.
// Input channel: frame_samples_i / end_of_block_i, taken when in_valid_i is
// high and in_stall_o is low. in_stall_o stays high while a word is processed.
// Output channel: out_samples_o / last_in_run_o, held while out_stall_i is
// high; last_in_run_o marks the final output frame caused by an input word.
// Config: cfg_we_i writes cfg_idx_i (0 channel count, 1 phase increment Q8.16)
// from cfg_data_i; write only while idle.
// Work: each output frame takes three serial multiplies per active lane and a
// shift past each inactive lane, plus control states. A word runs up to three
// source frames (at a block end), each giving ceil((1 - phase) / increment)
// outputs; a skipped frame gives none. Results are held one frame behind, so
// the last one can be flagged; it leaves after the word's final frame is done.
// Reset: empty window with a zero history frame, phase zero, no skip,
// channel count 2, increment 1.0. An output stall only stops the engine when
// both the output register and the pending frame are full.
module cubic_hermite_resampler_unit import chr_pkg::*; #(
  parameter int MAX_LANES   = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_W-1:0]     frame_samples_i,
  input  logic                  end_of_block_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_W-1:0]     out_samples_o,
  output logic                  last_in_run_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LW = MAX_LANES * SAMPLE_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALL  = 3'd1;
  localparam logic [2:0] S_POS   = 3'd2;
  localparam logic [2:0] S_LANE  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_PUSH  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  logic [2:0]           state_q;
  logic [CC_W-1:0]      cc_q, active;
  logic [INC_W-1:0]     inc_q, inc_eff;
  logic [LW-1:0]        win_q [4];
  logic [LW-1:0]        op_q [4];
  logic [1:0]           held_q, n_eff, calls_q;
  logic [2:0]           m_w;
  logic                 eob_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [7:0]           skip_q;
  logic [POS_W-1:0]     pos_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [CC_W-1:0]      lane_q;
  logic [LW-1:0]        res_q, pend_q, out_q;
  logic                 pend_vld_q, out_vld_q, out_last_q;
  logic                 out_free, out_load, accept, shift_win;
  logic                 h_start, h_done;
  logic [SAMPLE_BITS-1:0] h_y;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_vld_q || !out_stall_i;
  assign out_load = pend_vld_q && out_free &&
                    ((state_q == S_PUSH) || (state_q == S_FLUSH));
  assign inc_eff  = (inc_q == '0) ? INC_W'(1) : inc_q;
  assign active   = (cc_q > CC_W'(MAX_LANES)) ? CC_W'(MAX_LANES) : cc_q;
  assign n_eff    = (held_q == 2'd0) ? 2'd1 : held_q;
  assign m_w      = {1'b0, n_eff} + 3'd1;
  assign h_start  = (state_q == S_LANE) && (lane_q != CC_W'(MAX_LANES)) &&
                    (lane_q < active);

  // Window moves one frame after each source frame is handled
  assign shift_win = ((state_q == S_CALL) && (calls_q != 2'd0) && (skip_q != 8'd0)) ||
                     ((state_q == S_POS) && (|pos_q[POS_W-1:FRAC_BITS]));

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q  <= CC_W'(2);
      inc_q <= INC_W'(65536);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_CHANNEL_COUNT) cc_q <= cfg_data_i[CC_W-1:0];
      if (cfg_idx_i == CFG_PHASE_INC) inc_q <= cfg_data_i[INC_W-1:0];
    end
  end

  // Sample window: fixed entries, loaded on accept, shifted per source frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 4; j++) win_q[j] <= '0;
    end else if (accept) begin
      for (int j = 1; j < 4; j++) begin
        if (end_of_block_i ? (2'(j) >= n_eff) : (2'(j) == n_eff)) begin
          win_q[j] <= frame_samples_i[LW-1:0];
        end
      end
    end else if (shift_win) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= eob_q ? win_q[3] : '0;
    end else if (state_q == S_FLUSH && eob_q &&
                 (!pend_vld_q || out_free)) begin
      for (int j = 1; j < 4; j++) win_q[j] <= '0;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      held_q     <= 2'd1;
      calls_q    <= 2'd0;
      eob_q      <= 1'b0;
      frac_q     <= '0;
      skip_q     <= '0;
      pos_q      <= '0;
      cnt_q      <= '0;
      lane_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            eob_q <= end_of_block_i;
            cnt_q <= '0;
            if (end_of_block_i) begin
              calls_q <= n_eff;
              held_q  <= 2'd1;
            end else begin
              calls_q <= (m_w == 3'd4) ? 2'd1 : 2'd0;
              held_q  <= (m_w == 3'd4) ? 2'd3 : m_w[1:0];
            end
            state_q <= S_CALL;
          end
        end
        S_CALL: begin
          if (calls_q == 2'd0) begin
            state_q <= S_FLUSH;
          end else if (skip_q != 8'd0) begin
            skip_q  <= skip_q - 8'd1;
            calls_q <= calls_q - 2'd1;
          end else begin
            pos_q   <= POS_W'(frac_q);
            state_q <= S_POS;
          end
        end
        S_POS: begin
          if (|pos_q[POS_W-1:FRAC_BITS]) begin
            frac_q  <= pos_q[FRAC_BITS-1:0];
            skip_q  <= pos_q[FRAC_BITS+7:FRAC_BITS] - 8'd1;
            calls_q <= calls_q - 2'd1;
            state_q <= S_CALL;
          end else if (cnt_q == CNT_W'(OUT_CAP)) begin
            pos_q <= pos_q + POS_W'(inc_eff);
          end else begin
            lane_q  <= '0;
            state_q <= S_LANE;
          end
        end
        S_LANE: begin
          if (lane_q == CC_W'(MAX_LANES)) begin
            state_q <= S_PUSH;
          end else if (lane_q < active) begin
            state_q <= S_WAIT;
          end else begin
            lane_q <= lane_q + CC_W'(1);
          end
        end
        S_WAIT: begin
          if (h_done) begin
            lane_q  <= lane_q + CC_W'(1);
            state_q <= S_LANE;
          end
        end
        S_PUSH: begin
          if (!pend_vld_q || out_free) begin
            if (pend_vld_q) begin
              out_last_q <= 1'b0;
            end
            pend_vld_q <= 1'b1;
            cnt_q      <= cnt_q + CNT_W'(1);
            pos_q      <= pos_q + POS_W'(inc_eff);
            state_q    <= S_POS;
          end
        end
        S_FLUSH: begin
          if (!pend_vld_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_last_q <= 1'b1;
            pend_vld_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Lane operands and result frame, one lane per shift
  always_ff @(posedge clk_i) begin
    if (state_q == S_POS) begin
      for (int j = 0; j < 4; j++) op_q[j] <= win_q[j];
    end
    if ((state_q == S_LANE && lane_q != CC_W'(MAX_LANES) && !(lane_q < active)) ||
        (state_q == S_WAIT && h_done)) begin
      for (int j = 0; j < 4; j++) op_q[j] <= op_q[j] >> SAMPLE_BITS;
      res_q <= (res_q >> SAMPLE_BITS) |
               (LW'((state_q == S_WAIT) ? h_y : '0) << (LW - SAMPLE_BITS));
    end
    if (state_q == S_PUSH && (!pend_vld_q || out_free)) begin
      pend_q <= res_q;
      if (pend_vld_q) out_q <= pend_q;
    end
    if (state_q == S_FLUSH && pend_vld_q && out_free) begin
      out_q <= pend_q;
    end
  end

  chr_hermite #(.SampleBits(SAMPLE_BITS)) u_hermite (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (h_start),
    .f_i     (pos_q[FRAC_BITS-1:0]),
    .xm1_i   (op_q[0][SAMPLE_BITS-1:0]),
    .x0_i    (op_q[1][SAMPLE_BITS-1:0]),
    .x1_i    (op_q[2][SAMPLE_BITS-1:0]),
    .x2_i    (op_q[3][SAMPLE_BITS-1:0]),
    .done_o  (h_done),
    .y_o     (h_y)
  );

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_vld_q;
  assign out_samples_o = DATA_W'(out_q);
  assign last_in_run_o = out_last_q;

endmodule
